>>> design/lmpd_pkg.sv
// ----------------------------------------------------------------------------
// lmpd_pkg: shared definitions for the 3x3 local maximum peak detector
// Field widths, configuration register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package lmpd_pkg;

	// Width of one pixel and of the reported peak coordinates.
	localparam int PIX_W = 8;
	localparam int COORD_W = 10;

	// Configuration port: index width and data width (widest register).
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 11;

	// Width used to compare region dimensions against the maximum sizes.
	// It covers the largest allowed maximum size of 8192.
	localparam int DIM_CMP_W = 16;

	// Defaults for the size parameters of the top level.
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	// Reset value of the region size registers.
	localparam logic [CFG_DATA_W-1:0] DIM_RESET = CFG_DATA_W'(1024);

	// Smallest region size (one margin pixel on each side of one pixel).
	localparam int MIN_DIM = 3;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_STRICT    = 2'd1,
		REG_WIDTH     = 2'd2,
		REG_HEIGHT    = 2'd3
	} cfg_reg_t;

endpackage

>>> design/local_max_peak_detect_3x3_unit.sv
// ----------------------------------------------------------------------------
// local_max_peak_detect_3x3_unit: 3x3 local maximum peak detector
// Throughput: one pixel per clock cycle while the output is not stalled,
// sustained over rows and frames. An accepted pixel is held in stage s1;
// the accepting edge does the synchronous read of the line stores, and the
// output register is loaded when s1 moves on.
// Reset: counters, window, stage valid and output valid clear at once; the
// line stores hold no reset and are only read where a previous row wrote them.
// ----------------------------------------------------------------------------
module local_max_peak_detect_3x3_unit
	import lmpd_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,

	// Configuration write port.
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	// Pixel input channel.
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIX_W-1:0]      pixel,

	// Result output channel.
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  peak_found,
	output logic [PIX_W-1:0]      peak_value,
	output logic [COORD_W-1:0]    peak_x,
	output logic [COORD_W-1:0]    peak_y,
	output logic                  end_of_frame
);

	// Column and row counters are just wide enough to address the largest
	// region. The column counter doubles as the line store address.
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	// ------------------------------------------------------------------
	// Configuration registers. They are to be written only while the block is
	// idle; the block itself does not enforce this, so no shadowing is needed.
	// ------------------------------------------------------------------
	logic [PIX_W-1:0]      threshold_q;
	logic                  strict_q;
	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			strict_q    <= 1'b0;
			width_q     <= DIM_RESET;
			height_q    <= DIM_RESET;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD: threshold_q <= cfg_data[PIX_W-1:0];
				REG_STRICT:    strict_q    <= cfg_data[0];
				REG_WIDTH:     width_q     <= cfg_data;
				REG_HEIGHT:    height_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Last column and last row of the region. The programmed sizes are
	// saturated into the range from three up to the maximum size, and one
	// is taken off so that the counters compare against the last index.
	// ------------------------------------------------------------------
	logic [DIM_CMP_W-1:0] width_wide;
	logic [DIM_CMP_W-1:0] height_wide;
	logic [DIM_CMP_W-1:0] col_last_wide;
	logic [DIM_CMP_W-1:0] row_last_wide;
	logic [COL_W-1:0]     col_last_idx;
	logic [ROW_W-1:0]     row_last_idx;

	always_comb begin
		width_wide  = DIM_CMP_W'(width_q);
		height_wide = DIM_CMP_W'(height_q);

		if (width_wide < DIM_CMP_W'(MIN_DIM)) begin
			col_last_wide = DIM_CMP_W'(MIN_DIM - 1);
		end else if (width_wide > DIM_CMP_W'(MAX_WIDTH)) begin
			col_last_wide = DIM_CMP_W'(MAX_WIDTH - 1);
		end else begin
			col_last_wide = width_wide - DIM_CMP_W'(1);
		end

		if (height_wide < DIM_CMP_W'(MIN_DIM)) begin
			row_last_wide = DIM_CMP_W'(MIN_DIM - 1);
		end else if (height_wide > DIM_CMP_W'(MAX_HEIGHT)) begin
			row_last_wide = DIM_CMP_W'(MAX_HEIGHT - 1);
		end else begin
			row_last_wide = height_wide - DIM_CMP_W'(1);
		end

		col_last_idx = col_last_wide[COL_W-1:0];
		row_last_idx = row_last_wide[ROW_W-1:0];
	end

	// ------------------------------------------------------------------
	// Handshake and stage control.
	// Stage s1 holds the pixel whose line store data arrives this cycle.
	// It moves on whenever the output register is free or being emptied.
	// While it waits, the input stalls and the line stores keep re-reading
	// the held column, so the read data stays valid without a copy.
	// ------------------------------------------------------------------
	logic valid_s1;
	logic s1_adv;
	logic s1_fire;
	logic in_accept;
	logic out_valid_q;

	assign s1_adv    = !(out_valid_q && out_stall);
	assign s1_fire   = valid_s1 && s1_adv;
	assign in_stall  = valid_s1 && !s1_adv;
	assign in_accept = in_valid && !in_stall;

	// ------------------------------------------------------------------
	// Raster position counters. They advance when a pixel transaction
	// is accepted; the position of that pixel travels along with it.
	// ------------------------------------------------------------------
	logic [COL_W-1:0] column_count_q;
	logic [ROW_W-1:0] row_count_q;
	logic             row_end;
	logic             frame_end;

	assign row_end   = column_count_q >= col_last_idx;
	assign frame_end = row_end && (row_count_q >= row_last_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (in_accept) begin
			if (row_end) begin
				column_count_q <= '0;
				if (frame_end) begin
					row_count_q <= '0;
				end else begin
					row_count_q <= row_count_q + ROW_W'(1);
				end
			end else begin
				column_count_q <= column_count_q + COL_W'(1);
			end
		end
	end

	logic [PIX_W-1:0] pixel_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             eof_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pixel_s1 <= pixel;
			col_s1   <= column_count_q;
			row_s1   <= row_count_q;
			eof_s1   <= frame_end;
		end
	end

	// ------------------------------------------------------------------
	// Line stores. The upper store holds the row two above the incoming
	// pixel, the middle store the row just above it. Both are read at the
	// incoming column and written back in s1: the middle row moves up and
	// the new pixel takes its place in the middle store.
	// A write in s1 and the read for the next pixel never hit the same
	// column, since a row has at least three columns; every later read of
	// that column comes after the write has landed, so no bypass is needed.
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
	logic [COL_W-1:0] rd_addr;
	logic [PIX_W-1:0] top_s1;
	logic [PIX_W-1:0] mid_s1;

	assign rd_addr = in_stall ? col_s1 : column_count_q;

	always_ff @(posedge clk) begin
		top_s1 <= upper_mem[rd_addr];
		mid_s1 <= middle_mem[rd_addr];
		if (s1_fire) begin
			upper_mem[col_s1]  <= mid_s1;
			middle_mem[col_s1] <= pixel_s1;
		end
	end

	// ------------------------------------------------------------------
	// Window columns. The right column of the 3x3 window is formed by the
	// line store data and the s1 pixel; the center and left columns are
	// the two previous right columns.
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] win_lt_q, win_lm_q, win_lb_q;
	logic [PIX_W-1:0] win_ct_q, win_cm_q, win_cb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_lt_q <= '0;
			win_lm_q <= '0;
			win_lb_q <= '0;
			win_ct_q <= '0;
			win_cm_q <= '0;
			win_cb_q <= '0;
		end else if (s1_fire) begin
			win_lt_q <= win_ct_q;
			win_lm_q <= win_cm_q;
			win_lb_q <= win_cb_q;
			win_ct_q <= top_s1;
			win_cm_q <= mid_s1;
			win_cb_q <= pixel_s1;
		end
	end

	// ------------------------------------------------------------------
	// Neighbor test on the center pixel. In strict mode the left and
	// upper-row neighbors must be strictly lower; the right and lower-row
	// neighbors only need to be no higher in either mode. The test only
	// counts once two rows and two columns have been seen.
	// ------------------------------------------------------------------
	logic             in_window;
	logic             lead_ok;
	logic             trail_ok;
	logic             is_peak;
	logic             has_result;
	logic [COL_W-1:0] x_rel;
	logic [ROW_W-1:0] y_rel;

	always_comb begin
		in_window = (col_s1 >= COL_W'(2)) && (row_s1 >= ROW_W'(2));

		if (strict_q) begin
			lead_ok = (win_cm_q > win_lm_q) && (win_cm_q > win_lt_q) &&
				(win_cm_q > win_ct_q) && (win_cm_q > top_s1);
		end else begin
			lead_ok = (win_cm_q >= win_lm_q) && (win_cm_q >= win_lt_q) &&
				(win_cm_q >= win_ct_q) && (win_cm_q >= top_s1);
		end

		trail_ok = (win_cm_q >= mid_s1) && (win_cm_q >= pixel_s1) &&
			(win_cm_q >= win_cb_q) && (win_cm_q >= win_lb_q);

		is_peak    = in_window && (win_cm_q >= threshold_q) && lead_ok && trail_ok;
		has_result = is_peak || eof_s1;

		x_rel = col_s1 - COL_W'(2);
		y_rel = row_s1 - ROW_W'(2);
	end

	// ------------------------------------------------------------------
	// Output register. It holds a result transaction until the receiver
	// takes it; s1 can still take one more pixel meanwhile.
	// ------------------------------------------------------------------
	logic               found_q;
	logic [PIX_W-1:0]   value_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic               eof_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && has_result) begin
			found_q <= is_peak;
			eof_q   <= eof_s1;
			if (is_peak) begin
				value_q <= win_cm_q;
				x_q     <= COORD_W'(x_rel);
				y_q     <= COORD_W'(y_rel);
			end else begin
				value_q <= '0;
				x_q     <= '0;
				y_q     <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign peak_found   = found_q;
	assign peak_value   = value_q;
	assign peak_x       = x_q;
	assign peak_y       = y_q;
	assign end_of_frame = eof_q;

endmodule

>>> design/lmpd_checker.sv
// ----------------------------------------------------------------------------
// lmpd_checker: port-level checks for the 3x3 local maximum peak detector
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module lmpd_checker
	import lmpd_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  peak_found,
	input logic [PIX_W-1:0]      peak_value,
	input logic [COORD_W-1:0]    peak_x,
	input logic [COORD_W-1:0]    peak_y,
	input logic                  end_of_frame
);

	// A result transaction that is held back stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction withdrawn while stalled");

	// A result transaction that is held back keeps its fields.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(peak_found) && $stable(peak_value) &&
			$stable(peak_x) && $stable(peak_y) && $stable(end_of_frame))
		else $error("result fields changed while stalled");

	// The input side only waits when a result is held in the output register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output register");

	// A result without a peak can only be the end of a frame, with empty fields.
	a_no_peak_eof: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !peak_found |-> end_of_frame && peak_value == '0 &&
			peak_x == '0 && peak_y == '0)
		else $error("result without peak that is not a clean frame end");

endmodule

bind local_max_peak_detect_3x3_unit lmpd_checker u_lmpd_checker (.*);

>>> tb/local_max_peak_detect_3x3_unit_tb.sv
// ----------------------------------------------------------------------------
// local_max_peak_detect_3x3_unit_tb: self-checking bench for the peak detector
// Streams pixel regions through the detector under random input gaps and
// output stalls, predicts every peak and end-of-frame transaction in the
// bench, and checks each result field by field in arrival order.
// ----------------------------------------------------------------------------
module local_max_peak_detect_3x3_unit_tb
	import lmpd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W = DEF_MAX_WIDTH;
	localparam int MAX_H = DEF_MAX_HEIGHT;

	// The longest quiet stretch of a correct run is the long output hold-off;
	// anything far beyond that means a hang.
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 400;

	// One result transaction as the detector shows it.
	typedef struct packed {
		logic               found;
		logic [PIX_W-1:0]   value;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               eof;
	} peak_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [PIX_W-1:0]      pixel = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  peak_found;
	logic [PIX_W-1:0]      peak_value;
	logic [COORD_W-1:0]    peak_x;
	logic [COORD_W-1:0]    peak_y;
	logic                  end_of_frame;

	local_max_peak_detect_3x3_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel        (pixel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.peak_found   (peak_found),
		.peak_value   (peak_value),
		.peak_x       (peak_x),
		.peak_y       (peak_y),
		.end_of_frame (end_of_frame)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Pixels waiting for the driver, and results the detector still owes us.
	logic [PIX_W-1:0] pixel_backlog[$];
	peak_result_t     peaks_due[$];
	int unsigned      pixels_queued = 0;
	int unsigned      pixels_taken = 0;
	int unsigned      mismatch_count = 0;

	// Bench-side copy of the configuration registers, updated when a write
	// lands on the port. Dimensions are kept raw and clamped when used.
	logic [PIX_W-1:0]      thr_reg = '0;
	logic                  strict_reg = 1'b0;
	logic [CFG_DATA_W-1:0] width_raw = DIM_RESET;
	logic [CFG_DATA_W-1:0] height_raw = DIM_RESET;

	// Bench-side copy of the detector state: the two previous rows, the two
	// previous window columns and the raster position of the next pixel.
	logic [PIX_W-1:0] upper_row [MAX_W];
	logic [PIX_W-1:0] middle_row [MAX_W];
	logic [47:0]      win_cols = '0;
	int unsigned      col_pos = 0;
	int unsigned      row_pos = 0;

	// Long output hold-off: requested by the stimulus, timed by the receiver.
	logic             want_hold = 1'b0;
	logic             hold_taken = 1'b0;
	int unsigned      hold_left = 0;

	// Sender burst pattern and receiver stall pattern.
	int unsigned      burst_left = 0;
	int unsigned      gap_left = 0;
	int unsigned      stall_style = 0;
	int unsigned      style_left = 0;
	int unsigned      stall_tick = 0;
	int unsigned      quiet_cycles = 0;
	peak_result_t     oldest_peak;

	function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] raw,
		int unsigned hi);
		if (raw < MIN_DIM) return 32'(MIN_DIM);
		if (raw > hi) return hi;
		return 32'(raw);
	endfunction

	// Advances the bench copy of the detector by one pixel. When the pixel
	// completes a 3x3 window, the window center is tested; a result is owed
	// when the center is a peak or when this pixel closes the region.
	task automatic scan_pixel(input logic [PIX_W-1:0] px);
		int unsigned w, h, col, row;
		logic [PIX_W-1:0] top, mid, lt, lm, lb, ct, cc, cb;
		logic ok, found, eof;
		peak_result_t r;
		w = clamp_dim(width_raw, MAX_W);
		h = clamp_dim(height_raw, MAX_H);
		col = col_pos;
		row = row_pos;
		top = upper_row[col];
		mid = middle_row[col];
		found = 1'b0;
		eof = 1'b0;
		r = '0;
		if (row >= 2 && col >= 2) begin
			// Left column is col-2 (upper half of the window register),
			// center column is col-1, right column is the fresh pixel's.
			lt = win_cols[31:24];
			lm = win_cols[39:32];
			lb = win_cols[47:40];
			ct = win_cols[7:0];
			cc = win_cols[15:8];
			cb = win_cols[23:16];
			ok = cc >= thr_reg && cc >= mid && cc >= px && cc >= cb && cc >= lb;
			// Strict mode breaks ties against the neighbors already scanned, so a
			// plateau pixel with an equal left or upper-row neighbor is no peak.
			if (strict_reg)
				ok = ok && cc > lm && cc > lt && cc > ct && cc > top;
			else
				ok = ok && cc >= lm && cc >= lt && cc >= ct && cc >= top;
			if (ok) begin
				found = 1'b1;
				r.value = cc;
				r.x = COORD_W'(col - 2);
				r.y = COORD_W'(row - 2);
			end
		end
		upper_row[col] = mid;
		middle_row[col] = px;
		win_cols = {win_cols[23:0], px, mid, top};
		// A shrunk dimension takes effect at once: the row or the region ends
		// as soon as the counter reaches or passes its last index.
		if (col >= w - 1) begin
			col_pos = 0;
			if (row >= h - 1) begin
				eof = 1'b1;
				row_pos = 0;
			end else begin
				row_pos = row + 1;
			end
		end else begin
			col_pos = col + 1;
		end
		if (found || eof) begin
			r.found = found;
			r.eof = eof;
			peaks_due.push_back(r);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_count++;
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what,
			got, want);
	endtask

	// Driver: presents the backlog in bursts of random length separated by
	// random gaps. A stalled pixel is held unchanged until it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pixel_backlog.size() > 0) begin
				in_valid <= 1'b1;
				pixel <= pixel_backlog.pop_front();
				if (burst_left > 0) burst_left--;
				if (burst_left == 0) begin
					// Now and then a long burst, and now and then no gap before the next burst.
					burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stalls on a random pattern that is redrawn at random times,
	// and once holds off for a long stretch so the detector backs up.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (want_hold && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			if (style_left == 0) begin
				stall_style = $urandom_range(0, 3);
				style_left = $urandom_range(20, 120);
			end
			style_left--;
			stall_tick++;
			case (stall_style)
				0: out_stall <= 1'b0;
				1: out_stall <= 1'($urandom_range(0, 1));
				2: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= (stall_tick % 3 != 0);
			endcase
		end
	end

	// Monitor: checks each accepted result against the oldest expectation,
	// then feeds accepted pixels and register writes to the bench model.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (peaks_due.size() == 0) begin
					report_mismatch("result with none expected",
						32'({peak_found, peak_value, peak_x, peak_y, end_of_frame}), '0);
				end else begin
					oldest_peak = peaks_due.pop_front();
					if (peak_found !== oldest_peak.found)
						report_mismatch("peak_found", 32'(peak_found), 32'(oldest_peak.found));
					if (peak_value !== oldest_peak.value)
						report_mismatch("peak_value", 32'(peak_value), 32'(oldest_peak.value));
					if (peak_x !== oldest_peak.x)
						report_mismatch("peak_x", 32'(peak_x), 32'(oldest_peak.x));
					if (peak_y !== oldest_peak.y)
						report_mismatch("peak_y", 32'(peak_y), 32'(oldest_peak.y));
					if (end_of_frame !== oldest_peak.eof)
						report_mismatch("end_of_frame", 32'(end_of_frame),
							32'(oldest_peak.eof));
				end
			end
			if (in_valid && !in_stall) begin
				scan_pixel(pixel);
				pixels_taken++;
			end
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_THRESHOLD: thr_reg = cfg_data[PIX_W-1:0];
					REG_STRICT:    strict_reg = cfg_data[0];
					REG_WIDTH:     width_raw = cfg_data;
					REG_HEIGHT:    height_raw = cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Watchdog: ends the run when no transaction of any kind has happened
	// for far longer than a correct detector could need.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
			cfg_write) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_pixel(input logic [PIX_W-1:0] px);
		pixel_backlog.push_back(px);
		pixels_queued++;
	endtask

	// Region content: uniform noise, near-flat values full of ties, sparse
	// bright spikes on a dark background, or one flat level.
	task automatic queue_frame_data(input int unsigned count, input int unsigned style);
		int unsigned base, v;
		base = $urandom_range(0, 255);
		for (int unsigned i = 0; i < count; i++) begin
			case (style)
				0: v = $urandom_range(0, 255);
				1: v = (base > 252) ? base - $urandom_range(0, 3) : base + $urandom_range(0, 3);
				2: v = ($urandom_range(0, 15) == 0) ? $urandom_range(128, 255) :
					$urandom_range(0, 40);
				default: v = base;
			endcase
			queue_pixel(PIX_W'(v));
		end
	endtask

	// Waits until every queued pixel is taken and every owed result is in,
	// then lets the pipeline drain, since the last pixels may owe nothing.
	task automatic settle();
		do @(posedge clk);
		while (pixels_taken != pixels_queued || peaks_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic apply_setup(input int unsigned thr, input int unsigned strict_sel,
		input int unsigned w_raw, input int unsigned h_raw);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_STRICT, strict_sel);
		write_reg(REG_WIDTH, w_raw);
		write_reg(REG_HEIGHT, h_raw);
	endtask

	initial begin
		int unsigned random_items, cur_w, cur_h, w_raw, h_raw, count, thr;
		logic [PIX_W-1:0] opening [7];
		foreach (upper_row[i]) begin
			upper_row[i] = '0;
			middle_row[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Start in the reset configuration (1024 x 1024), then shrink both
		// dimensions below the minimum in the middle of the first row. The
		// row must end on the next pixel and the region after three rows,
		// with the bright center, tied by two corners above it, as its only peak.
		queue_pixel(8'hFF);
		queue_pixel(8'h00);
		queue_pixel(8'hFF);
		queue_pixel(8'h00);
		settle();
		write_reg(REG_WIDTH, 2);
		write_reg(REG_HEIGHT, 1);
		opening = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
		foreach (opening[i]) queue_pixel(opening[i]);
		settle();

		// A flat full-scale region at the top threshold: strict mode finds
		// no peak (only the end-of-frame transaction comes), plain mode does.
		apply_setup(255, 1, 3, 3);
		for (int i = 0; i < 9; i++) queue_pixel(8'hFF);
		settle();
		write_reg(REG_STRICT, 0);
		for (int i = 0; i < 9; i++) queue_pixel(8'hFF);
		settle();

		// Pressure: a flat region where every interior pixel is a peak while
		// the receiver holds off, so the detector fills and stalls its input.
		apply_setup(0, 0, 16, 8);
		want_hold = 1'b1;
		queue_frame_data(128, 3);
		settle();

		// Random phases. A phase rewrites all registers while idle, then
		// streams whole regions or a partial one. In the middle of a region
		// the width may only shrink, so no line store entry is ever read
		// before the current region has written it.
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			cur_w = clamp_dim(width_raw, MAX_W);
			if (col_pos == 0 && row_pos == 0)
				w_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) :
					$urandom_range(3, 24);
			else
				w_raw = ($urandom_range(0, 2) == 0) ? $urandom_range(0, cur_w) :
					32'(width_raw);
			h_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) :
				$urandom_range(3, 16);
			thr = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 255) :
				$urandom_range(0, 32);
			apply_setup(thr, $urandom_range(0, 1), w_raw, h_raw);
			cur_w = clamp_dim(w_raw, MAX_W);
			cur_h = clamp_dim(h_raw, MAX_H);
			if ($urandom_range(0, 9) < 7)
				count = cur_w * cur_h * $urandom_range(1, 2);
			else
				count = $urandom_range(1, cur_w * cur_h);
			queue_frame_data(count, $urandom_range(0, 3));
			random_items += count;
			settle();
		end

		// Close the open region before the widest setting takes effect.
		cur_w = clamp_dim(width_raw, MAX_W);
		cur_h = clamp_dim(height_raw, MAX_H);
		if (col_pos != 0 || row_pos != 0) begin
			count = (col_pos >= cur_w - 1) ? 1 : cur_w - col_pos;
			if (row_pos < cur_h - 1) count += (cur_h - 1 - row_pos) * cur_w;
			queue_frame_data(count, 0);
			settle();
		end

		// Largest width: an over-range width saturates to the widest row, so
		// the first row ends on its last allowed column. The width then
		// shrinks to the minimum and two short rows close the region.
		apply_setup($urandom_range(0, 64), 0, 2047, 3);
		queue_frame_data(MAX_W, 0);
		settle();
		write_reg(REG_WIDTH, 3);
		queue_frame_data(6, 0);
		settle();

		repeat (12) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
design/lmpd_pkg.sv
design/local_max_peak_detect_3x3_unit.sv
design/lmpd_checker.sv
tb/local_max_peak_detect_3x3_unit_tb.sv
